[rtl/urpe_pkg.sv]
`default_nettype none

package urpe_pkg;

	// Port status and control bit positions
	localparam int unsigned B_CCS = 0;
	localparam int unsigned B_PED = 1;
	localparam int unsigned B_OCA = 3;
	localparam int unsigned B_PLS_LO = 5;
	localparam int unsigned B_CSC = 17;
	localparam int unsigned B_PEC = 18;
	localparam int unsigned B_WRC = 19;
	localparam int unsigned B_OCC = 20;
	localparam int unsigned B_PRC = 21;
	localparam int unsigned B_CEC = 23;
	localparam int unsigned B_CAS = 24;

	localparam logic [31:0] CHANGE_MASK = 32'h01FE_0000;
	localparam logic [3:0] PLS_INACTIVE = 4'd6;
	localparam logic [31:0] PRESERVE_RESET = 32'h0E01_C3E0;

	localparam int unsigned CFG_IDX_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_USB3_PORTS = 8'd0,
		CFG_PRESERVE_MASK = 8'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_DISC = 2'd0,
		ST_WAIT_HOT = 2'd1,
		ST_WAIT_WARM = 2'd2,
		ST_ENABLED = 2'd3
	} port_state_t;

	// One entry of the per-port state memory
	typedef struct packed {
		logic dev;
		port_state_t st;
	} entry_t;

	// Decision for one event
	typedef struct packed {
		port_state_t next_state;
		logic dev;
		logic ack_write;
		logic [31:0] ack_value;
		logic power_off;
		logic power_on;
		logic warm_reset;
		logic hot_reset;
		logic start_enumeration;
		logic device_removed;
	} result_t;

endpackage

`default_nettype wire

[rtl/urpe_rules.sv]
`default_nettype none

module urpe_rules (
	input  wire logic [31:0] status,
	input  wire urpe_pkg::entry_t cur,
	input  wire logic usb3,
	input  wire logic [31:0] preserve_mask,
	output urpe_pkg::result_t res
);

	always_comb begin
		logic [31:0] chg;
		logic done;
		urpe_pkg::port_state_t st;
		logic dev;

		chg = status & urpe_pkg::CHANGE_MASK;
		st = cur.st;
		dev = cur.dev;
		done = 1'b0;
		res = '0;

		if (chg != 32'd0) begin
			res.ack_write = 1'b1;
			res.ack_value = (status & preserve_mask) | chg;
		end

		// over-current is checked first; an active over-current ends the decision
		if (status[urpe_pkg::B_OCC]) begin
			if (status[urpe_pkg::B_OCA]) begin
				res.power_off = 1'b1;
				st = urpe_pkg::ST_DISC;
				res.device_removed = dev;
				dev = 1'b0;
				done = 1'b1;
			end else begin
				res.power_on = 1'b1;
			end
		end

		if (!done && status[urpe_pkg::B_CEC]) begin
			st = urpe_pkg::ST_DISC;
			done = 1'b1;
		end

		if (!done && (status[urpe_pkg::B_CSC] || status[urpe_pkg::B_CAS] ||
				(status[urpe_pkg::B_CCS] && st == urpe_pkg::ST_DISC))) begin
			if (status[urpe_pkg::B_CCS]) begin
				if (usb3 && status[urpe_pkg::B_PLS_LO +: 4] == urpe_pkg::PLS_INACTIVE) begin
					res.warm_reset = 1'b1;
					st = urpe_pkg::ST_WAIT_WARM;
				end else begin
					res.hot_reset = 1'b1;
					st = urpe_pkg::ST_WAIT_HOT;
				end
			end else begin
				st = urpe_pkg::ST_DISC;
				res.device_removed = dev;
				dev = 1'b0;
			end
			done = 1'b1;
		end

		if (!done) begin
			if ((status[urpe_pkg::B_PRC] || status[urpe_pkg::B_WRC]) &&
					(st == urpe_pkg::ST_WAIT_HOT || st == urpe_pkg::ST_WAIT_WARM)) begin
				if (status[urpe_pkg::B_PED]) begin
					st = urpe_pkg::ST_ENABLED;
					res.start_enumeration = 1'b1;
					dev = 1'b1;
				end else begin
					st = urpe_pkg::ST_DISC;
				end
			end
			if (status[urpe_pkg::B_PEC] && !status[urpe_pkg::B_PED] &&
					st == urpe_pkg::ST_ENABLED) begin
				st = urpe_pkg::ST_DISC;
				res.device_removed = dev;
				dev = 1'b0;
			end
		end

		res.next_state = st;
		res.dev = dev;
	end

endmodule

`default_nettype wire

[rtl/usb_root_port_event_fsm.sv]
// Channel  | Direction | Payload (low bit first)
// ---------+-----------+----------------------------------------------------------
// s_axis   | in        | port_number[4:0], port_status[36:5]
// m_axis   | out       | port_echo, next_state, ack_write, ack_value, power_off,
//          |           | power_on, warm_reset, hot_reset, start_enumeration,
//          |           | device_removed
// cfg      | in        | cfg_index selects usb3_ports (0) or preserve_mask (1)
//
// One event per cycle unless the output stalls; stage 1 and the output are registered.
// The rate is set by the read-modify-write of the per-port state memory: the read
// is issued at accept, and a write to the same port at that edge is forwarded.
// Reset clears a per-port valid bit array; no clearing pass over the memory.
// A stalled output holds the pipeline stage; the input keeps taking events until
// both the stage and the output register are full.
`default_nettype none

module usb_root_port_event_fsm #(
	parameter int NUM_PORTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [39:0] s_axis_tdata, // port_number[4:0], port_status[36:5], zero

	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // port_echo[4:0], next_state[6:5], ack_write[7],
	                                   // ack_value[39:8], power_off[40], power_on[41],
	                                   // warm_reset[42], hot_reset[43],
	                                   // start_enumeration[44], device_removed[45], zero

	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [urpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	// configuration registers
	logic [15:0] usb3_q;
	logic [31:0] preserve_q;

	// input decode
	logic s_accept;
	logic [4:0] in_pn;
	logic [31:0] in_ps;
	logic [4:0] in_idx5;
	logic [IDX_W-1:0] in_idx;
	logic in_range;
	logic in_usb3;

	// stage 1: memory read in flight
	logic s1_vld_q;
	logic [4:0] pn_s1;
	logic [31:0] ps_s1;
	logic [IDX_W-1:0] idx_s1;
	logic usb3_s1;
	urpe_pkg::entry_t rd_s1;
	logic fwd_s1;
	urpe_pkg::entry_t fwd_data_s1;

	// state memory and valid bits
	urpe_pkg::entry_t mem [NUM_PORTS];
	logic [NUM_PORTS-1:0] vld_bits_q;

	logic advance;
	urpe_pkg::entry_t cur;
	urpe_pkg::entry_t wdata;
	urpe_pkg::result_t res;

	// output register
	logic m_valid_q;
	logic [47:0] out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usb3_q <= '0;
			preserve_q <= urpe_pkg::PRESERVE_RESET;
		end else if (cfg_valid) begin
			// drop writes to unknown indexes
			if (cfg_index == urpe_pkg::CFG_USB3_PORTS) begin
				usb3_q <= cfg_data[15:0];
			end else if (cfg_index == urpe_pkg::CFG_PRESERVE_MASK) begin
				preserve_q <= cfg_data;
			end
		end
	end

	assign s_accept = s_axis_tvalid & s_axis_tready;
	assign in_pn = s_axis_tdata[4:0];
	assign in_ps = s_axis_tdata[36:5];
	assign in_idx5 = in_pn - 5'd1;
	assign in_idx = IDX_W'(in_idx5);
	// port numbers of zero or beyond the last port are taken and dropped
	assign in_range = (in_pn != 5'd0) && (32'(in_pn) <= 32'(NUM_PORTS));
	// ports above sixteen have no usb3 bit and count as USB 2
	assign in_usb3 = ~in_idx5[4] & usb3_q[in_idx5[3:0]];

	// advance stage 1 when the output register is free or drains this cycle
	assign advance = s1_vld_q & (~m_valid_q | m_axis_tready);
	assign s_axis_tready = ~s1_vld_q | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_accept) begin
			s1_vld_q <= in_range;
		end else if (advance) begin
			s1_vld_q <= 1'b0;
		end
	end

	// capture the event and issue the read; a write to the same port at this
	// edge lands after the read, so forward its data
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pn_s1 <= in_pn;
			ps_s1 <= in_ps;
			idx_s1 <= in_idx;
			usb3_s1 <= in_usb3;
			rd_s1 <= mem[in_idx];
			fwd_s1 <= advance && (idx_s1 == in_idx);
			fwd_data_s1 <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mem[idx_s1] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_bits_q <= '0;
		end else if (advance) begin
			vld_bits_q[idx_s1] <= 1'b1;
		end
	end

	// a never-written entry reads as disconnected with no device
	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (vld_bits_q[idx_s1]) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
	end

	urpe_rules u_rules (
		.status(ps_s1),
		.cur(cur),
		.usb3(usb3_s1),
		.preserve_mask(preserve_q),
		.res(res)
	);

	assign wdata.dev = res.dev;
	assign wdata.st = res.next_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {2'b00, res.device_removed, res.start_enumeration,
				res.hot_reset, res.warm_reset, res.power_on, res.power_off,
				res.ack_value, res.ack_write, res.next_state, pn_s1};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = out_data_q;

`ifndef NO_ASSERTIONS
	// an out-of-range port must never enter the pipeline
	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && !in_range |=> !s1_vld_q)
		else $error("out-of-range port entered stage 1");

	// a held stage keeps its event and port index
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && !advance |=> s1_vld_q && $stable(idx_s1) && $stable(ps_s1))
		else $error("stage 1 lost its event while stalled");

	// power off leaves the port disconnected without power-on
	a_poff_disc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[40] |->
		m_axis_tdata[6:5] == urpe_pkg::ST_DISC && !m_axis_tdata[41])
		else $error("power off with port not disconnected");

	// enumeration start always leaves the port enabled with a device
	a_enum_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.start_enumeration |->
		res.next_state == urpe_pkg::ST_ENABLED && res.dev)
		else $error("enumeration started on a port not enabled");
`endif

endmodule

`default_nettype wire
